// File: src/ir_pulse_width_frame_decoder_defines.svh
// Assertion macros used by the checker of the IR pulse width decoder.
// Depends on nothing; expects clk and arst_n to exist where the macros are used.
`ifndef IR_PULSE_WIDTH_FRAME_DECODER_DEFINES_SVH
`define IR_PULSE_WIDTH_FRAME_DECODER_DEFINES_SVH

// Concurrent assertion on the block clock, switched off while reset is held.
`define IRPWFD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same, for a property that holds only in the cycle after the condition.
`define IRPWFD_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: src/irpwfd_pkg.sv
// Shared types and constants of the IR pulse width frame decoder.
// Used by the classifier, the frame tracker, the top level and the checker.
`default_nettype none

package irpwfd_pkg;

	localparam int PW_W       = 16;  // width of a pulse width and of every register
	localparam int CMD_W      = 32;  // width of the command word on the output
	localparam int IDX_W      = 3;   // width of the register index
	localparam int IN_TDATA_W = 16;  // pulse_width, already whole bytes
	localparam int OUT_TDATA_W = 40; // command_word, repeat_seen, zero padding

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_START  = 3'd0;
	localparam logic [IDX_W-1:0] REG_ONE    = 3'd1;
	localparam logic [IDX_W-1:0] REG_ZERO   = 3'd2;
	localparam logic [IDX_W-1:0] REG_END    = 3'd3;
	localparam logic [IDX_W-1:0] REG_REPEAT = 3'd4;
	localparam logic [IDX_W-1:0] REG_COMMA  = 3'd5;
	localparam logic [IDX_W-1:0] REG_TOL    = 3'd6;

	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_START,
		CLS_ONE,
		CLS_ZERO,
		CLS_END,
		CLS_REPEAT,
		CLS_COMMA
	} pulse_class_t;

	typedef struct packed {
		logic [PW_W-1:0] start_width;
		logic [PW_W-1:0] one_width;
		logic [PW_W-1:0] zero_width;
		logic [PW_W-1:0] end_width;
		logic [PW_W-1:0] repeat_width;
		logic [PW_W-1:0] comma_width;
		logic [PW_W-1:0] tolerance;
	} cfg_regs_t;

	// Control from the top level to the frame tracker.
	typedef struct packed {
		logic         fire;
		pulse_class_t cls;
	} frame_ctl_t;

endpackage

`default_nettype wire

// File: src/irpwfd_classify.sv
// Sorts one pulse width into a class by strict window compares against the registers.
// Depends on irpwfd_pkg for the register struct and the class codes.
`default_nettype none

module irpwfd_classify
	import irpwfd_pkg::*;
(
	input  wire logic [PW_W-1:0] pulse_width,
	input  wire cfg_regs_t       regs,
	output pulse_class_t         cls
);

	// nominal - tol < w < nominal + tol, done on one extra bit so nothing wraps.
	function automatic logic in_window(input logic [PW_W-1:0] w,
		input logic [PW_W-1:0] nominal, input logic [PW_W-1:0] tol);
		logic [PW_W:0] w_plus_t;
		logic [PW_W:0] n_plus_t;
		w_plus_t = {1'b0, w} + {1'b0, tol};
		n_plus_t = {1'b0, nominal} + {1'b0, tol};
		return (w_plus_t > {1'b0, nominal}) && ({1'b0, w} < n_plus_t);
	endfunction

	logic hit_start, hit_one, hit_zero, hit_end, hit_repeat, hit_comma;

	assign hit_start  = in_window(pulse_width, regs.start_width, regs.tolerance);
	assign hit_one    = in_window(pulse_width, regs.one_width, regs.tolerance);
	assign hit_zero   = in_window(pulse_width, regs.zero_width, regs.tolerance);
	assign hit_end    = in_window(pulse_width, regs.end_width, regs.tolerance);
	assign hit_repeat = in_window(pulse_width, regs.repeat_width, regs.tolerance);
	assign hit_comma  = in_window(pulse_width, regs.comma_width, regs.tolerance);

	// The first matching class wins.
	always_comb begin
		if (hit_start) begin
			cls = CLS_START;
		end else if (hit_one) begin
			cls = CLS_ONE;
		end else if (hit_zero) begin
			cls = CLS_ZERO;
		end else if (hit_end) begin
			cls = CLS_END;
		end else if (hit_repeat) begin
			cls = CLS_REPEAT;
		end else if (hit_comma) begin
			cls = CLS_COMMA;
		end else begin
			cls = CLS_NONE;
		end
	end

endmodule

`default_nettype wire

// File: src/irpwfd_frame.sv
// Frame state: shift word, bit count, start and repeat flags, and the latched command.
// Depends on irpwfd_pkg for the class codes and the control struct.
`default_nettype none

module irpwfd_frame
	import irpwfd_pkg::*;
#(
	parameter int FRAME_BITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire frame_ctl_t       ctl,
	output logic [CMD_W-1:0]      command_word,
	output logic                  repeat_seen
);

	localparam int CNT_W  = $clog2(FRAME_BITS + 2);
	localparam int KEEP_W = (FRAME_BITS < CMD_W) ? FRAME_BITS : CMD_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAME_BITS);
	localparam logic [CNT_W-1:0] SAT_CNT  = CNT_W'(FRAME_BITS + 1);

	logic [FRAME_BITS-1:0] shift_word_q;
	logic [CNT_W-1:0]      bit_count_q;
	logic                  frame_started_q;
	logic                  repeat_q;
	logic [KEEP_W-1:0]     command_q;

	logic take_bit;
	logic bit_value;

	assign take_bit  = ctl.fire && frame_started_q &&
		(ctl.cls == CLS_ONE || ctl.cls == CLS_ZERO);
	assign bit_value = (ctl.cls == CLS_ONE);

	// Bits arrive most significant first; bit_count picks the position.
	always_ff @(posedge clk) begin
		if (take_bit && bit_count_q < FULL_CNT) begin
			for (int i = 0; i < FRAME_BITS; i++) begin
				if (CNT_W'(FRAME_BITS - 1 - i) == bit_count_q) begin
					shift_word_q[i] <= bit_value;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q     <= '0;
			frame_started_q <= 1'b0;
			repeat_q        <= 1'b0;
			command_q       <= '0;
		end else if (ctl.fire) begin
			case (ctl.cls)
				CLS_START: begin
					bit_count_q     <= '0;
					frame_started_q <= 1'b1;
				end
				CLS_ONE, CLS_ZERO: begin
					if (frame_started_q && bit_count_q < SAT_CNT) begin
						bit_count_q <= bit_count_q + CNT_W'(1);
					end
				end
				CLS_END: begin
					if (frame_started_q && bit_count_q == FULL_CNT) begin
						command_q <= shift_word_q[KEEP_W-1:0];
					end else begin
						command_q <= '0;
					end
					repeat_q        <= 1'b0;
					frame_started_q <= 1'b0;
					bit_count_q     <= '0;
				end
				CLS_REPEAT: begin
					repeat_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign command_word = CMD_W'(command_q);
	assign repeat_seen  = repeat_q;

endmodule

`default_nettype wire

// File: src/ir_pulse_width_frame_decoder.sv
// Top level of the IR pulse width frame decoder: streams, config registers, output register.
// Depends on irpwfd_pkg, irpwfd_classify and irpwfd_frame.
`default_nettype none

// Decodes a stream of measured IR pulse widths (capture ticks) into remote-control
// frames. Each width is compared against six nominal widths, each with a strict
// window of plus or minus the tolerance, in the order start, one, zero, end, repeat,
// comma; the first match acts. Start opens a frame, one and zero bits are shifted in
// most significant bit first, end latches the word as the command (or 0 when the
// frame was not started or did not hold exactly FRAME_BITS bits) and clears the
// repeat flag, repeat sets it, and comma emits one result transaction carrying the
// latched command and the repeat flag. Other widths are dropped without a result.
// The block takes one width per clock while the input register is not held: the
// width sits in an input register, the class compare runs on it and, as the width
// moves on, updates the frame state, and a comma loads the output register, from
// which the result is presented.
// The input keeps flowing while a result waits; only a comma that finds
// the output register still full and not being taken holds the input register.
// Registers are written through the configuration channel, which is always ready;
// write only while no width is in flight. Indexes above 6 are ignored.
module ir_pulse_width_frame_decoder
	import irpwfd_pkg::*;
#(
	parameter int FRAME_BITS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Input stream, one pulse width per transaction.
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] pulse_width
	// Result stream, one transaction per comma pulse.
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [31:0] command_word,
	                                                    // [32] repeat_seen, [39:33] zero
	// Configuration write channel.
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [IDX_W-1:0]       cfg_index,
	input  wire logic [PW_W-1:0]        cfg_data
);

	cfg_regs_t regs_q;

	logic            valid_s1;
	logic [PW_W-1:0] pulse_width_s1;

	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	pulse_class_t    cls;
	logic            advance;
	frame_ctl_t      ctl;
	logic [CMD_W-1:0] command_word;
	logic            repeat_seen;

	// The configuration channel never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.start_width  <= PW_W'(45);
			regs_q.one_width    <= PW_W'(17);
			regs_q.zero_width   <= PW_W'(6);
			regs_q.end_width    <= PW_W'(400);
			regs_q.repeat_width <= PW_W'(22);
			regs_q.comma_width  <= PW_W'(1000);
			regs_q.tolerance    <= PW_W'(3);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_START:  regs_q.start_width  <= cfg_data;
				REG_ONE:    regs_q.one_width    <= cfg_data;
				REG_ZERO:   regs_q.zero_width   <= cfg_data;
				REG_END:    regs_q.end_width    <= cfg_data;
				REG_REPEAT: regs_q.repeat_width <= cfg_data;
				REG_COMMA:  regs_q.comma_width  <= cfg_data;
				REG_TOL:    regs_q.tolerance    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	irpwfd_classify u_classify (
		.pulse_width (pulse_width_s1),
		.regs        (regs_q),
		.cls         (cls)
	);

	// The width in the input register moves on unless it is a comma and the output
	// register is occupied by a result that is not taken in this cycle.
	assign advance = !valid_s1 || (cls != CLS_COMMA) || !m_valid_q || m_axis_tready;
	assign s_axis_tready = advance;

	assign ctl.fire = valid_s1 && advance;
	assign ctl.cls  = cls;

	irpwfd_frame #(
		.FRAME_BITS (FRAME_BITS)
	) u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.command_word (command_word),
		.repeat_seen  (repeat_seen)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s_axis_tvalid) begin
			pulse_width_s1 <= s_axis_tdata[PW_W-1:0];
		end
	end

	// A comma reads the latched command; it changes no frame state itself.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctl.fire && cls == CLS_COMMA) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fire && cls == CLS_COMMA) begin
			m_data_q <= {(OUT_TDATA_W - CMD_W - 1)'(0), repeat_seen, command_word};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

// File: src/irpwfd_checker.sv
// Port-level checks for the IR pulse width frame decoder, bound to its top level.
// Depends on irpwfd_pkg and the assertion macros in the defines header.
`default_nettype none
`include "ir_pulse_width_frame_decoder_defines.svh"

module irpwfd_checker
	import irpwfd_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_axis_tvalid,
	input wire logic                   s_axis_tready,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// A stalled result keeps its value.
	`IRPWFD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	// A new result only follows an accepted width, through the input and output registers.
	`IRPWFD_ASSERT(a_out_latency, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2), "result without a matching input")

	// The input only stalls behind a result that is waiting.
	`IRPWFD_ASSERT(a_in_ready, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

	// Padding above the repeat flag stays zero.
	`IRPWFD_ASSERT(a_pad_zero, m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:CMD_W+1] == '0), "nonzero padding in result")

endmodule

bind ir_pulse_width_frame_decoder irpwfd_checker u_irpwfd_checker (.*);

`default_nettype wire
